// ===== design/rcpfm_pkg.sv =====
// Package with shared types, codes and constants of the servo pulse selector.
`default_nettype none

package rcpfm_pkg;

  localparam int W_WIDTH = 16;
  localparam int W_CMD   = 12;
  localparam int W_AGE   = 10;
  localparam int W_HOLD  = 9;
  localparam int N_CH    = 4;
  localparam int W_CH    = 2;

  localparam int W_S_TDATA = 40;
  localparam int W_M_TDATA = 64;
  localparam int W_CFG_IDX = 3;
  localparam int W_CFG_DAT = 16;

  localparam logic [W_AGE-1:0] AGE_CAP   = 10'd1000;
  localparam logic [W_AGE-1:0] AGE_RESET = 10'd100;
  localparam logic [W_CMD-1:0] HOST_WIDTH_RESET = 12'd1500;

  localparam logic [W_AGE-1:0]   STALE_LIMIT_RESET   = 10'd100;
  localparam logic [W_WIDTH-1:0] CENTER_LOW_RESET    = 16'd1400;
  localparam logic [W_WIDTH-1:0] CENTER_HIGH_RESET   = 16'd1600;
  localparam logic [W_HOLD-1:0]  OVERRIDE_HOLD_RESET = 9'd500;
  localparam logic [W_WIDTH-1:0] NEUTRAL_WIDTH_RESET = 16'd1500;
  localparam logic [W_CMD-1:0]   CMD_MIN_RESET       = 12'd900;
  localparam logic [W_CMD-1:0]   CMD_MAX_RESET       = 12'd2100;

  localparam logic [W_CFG_IDX-1:0] REG_STALE_LIMIT   = 3'd0;
  localparam logic [W_CFG_IDX-1:0] REG_CENTER_LOW    = 3'd1;
  localparam logic [W_CFG_IDX-1:0] REG_CENTER_HIGH   = 3'd2;
  localparam logic [W_CFG_IDX-1:0] REG_OVERRIDE_HOLD = 3'd3;
  localparam logic [W_CFG_IDX-1:0] REG_NEUTRAL_WIDTH = 3'd4;
  localparam logic [W_CFG_IDX-1:0] REG_CMD_MIN       = 3'd5;
  localparam logic [W_CFG_IDX-1:0] REG_CMD_MAX       = 3'd6;

  localparam logic [3:0] CMD_CH_FIRST = 4'd1;
  localparam logic [3:0] CMD_CH_LAST  = 4'd4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    FUNC_CAPTURE = 2'd0,
    FUNC_COMMAND = 2'd1,
    FUNC_TICK    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    SRC_HOST     = 2'd0,
    SRC_RECEIVER = 2'd1,
    SRC_NEUTRAL  = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    OP_CAPTURE,
    OP_COMMAND,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [W_AGE-1:0]   stale_limit;
    logic [W_WIDTH-1:0] center_low;
    logic [W_WIDTH-1:0] center_high;
    logic [W_HOLD-1:0]  override_hold;
    logic [W_WIDTH-1:0] neutral_width;
    logic [W_CMD-1:0]   cmd_min;
    logic [W_CMD-1:0]   cmd_max;
  } cfg_t;

  // One classified event waiting for the back end.
  typedef struct packed {
    op_t                op;
    logic [W_CH-1:0]    ch;
    logic [W_WIDTH-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [Q_AW:0]   count;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== design/rc_pulse_failsafe_mux_core.sv =====
// Top level of the four-channel servo pulse selector with failsafe.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    event: tuser kind, tdata fields
//  m_*       out        m_tvalid/m_tready    four widths in tdata, source in tuser
//  cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// The front end classifies each event without a register and the queue stores it; a new
// transaction can be accepted on every clock while the queue is not full, and a tick's
// result appears on m_* in the cycle after the back end retires it. The back end retires
// one event per cycle while the queue holds one and, for a tick, the output is free.
// A four-entry queue decouples the two ends: while a result waits on m_tready,
// captures and commands ahead of the next tick keep retiring, and the queue absorbs up
// to four events before s_tready falls. rst is synchronous and resets the config, the
// queue pointers and channel state, not data registers; no clearing pass is needed.
`default_nettype none

module rc_pulse_failsafe_mux_core (
  input  wire                                 clk,
  input  wire                                 rst,
  // Event stream.
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // tdata, lowest bit up: channel[1:0], capture_count[17:2], cmd_channel[21:18],
  // cmd_width[33:22], zero pad[39:34].
  input  wire  [rcpfm_pkg::W_S_TDATA-1:0]     s_tdata,
  // tuser: func[1:0].
  input  wire  [1:0]                          s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // tdata, lowest bit up: out_width0[15:0], out_width1[31:16], out_width2[47:32],
  // out_width3[63:48].
  output logic [rcpfm_pkg::W_M_TDATA-1:0]     m_tdata,
  // tuser: source[1:0].
  output logic [1:0]                          m_tuser,
  // Configuration writes.
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [rcpfm_pkg::W_CFG_IDX-1:0]     cfg_index,
  input  wire  [rcpfm_pkg::W_CFG_DAT-1:0]     cfg_data
);
  import rcpfm_pkg::*;

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;

  // The register file takes a write transaction in any cycle. Values are cut to
  // the width of each register, and indexes past the last register are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_limit   <= STALE_LIMIT_RESET;
      cfg.center_low    <= CENTER_LOW_RESET;
      cfg.center_high   <= CENTER_HIGH_RESET;
      cfg.override_hold <= OVERRIDE_HOLD_RESET;
      cfg.neutral_width <= NEUTRAL_WIDTH_RESET;
      cfg.cmd_min       <= CMD_MIN_RESET;
      cfg.cmd_max       <= CMD_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STALE_LIMIT:   cfg.stale_limit   <= cfg_data[W_AGE-1:0];
        REG_CENTER_LOW:    cfg.center_low    <= cfg_data;
        REG_CENTER_HIGH:   cfg.center_high   <= cfg_data;
        REG_OVERRIDE_HOLD: cfg.override_hold <= cfg_data[W_HOLD-1:0];
        REG_NEUTRAL_WIDTH: cfg.neutral_width <= cfg_data;
        REG_CMD_MIN:       cfg.cmd_min       <= cfg_data[W_CMD-1:0];
        REG_CMD_MAX:       cfg.cmd_max       <= cfg_data[W_CMD-1:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each event; commands that fail the checks and the
  // unused event kind never enter the queue.
  rcpfm_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  rcpfm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // The back end holds the channel state. A tick retires only when the output
  // register is free, so results leave in event order.
  rcpfm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // The queue never holds more than its depth, and never pops when empty.
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    (q_stat.count <= (Q_AW+1)'(Q_DEPTH)) && !(pop && q_stat.empty))
    else $error("queue occupancy out of range");

  // A tick must not retire while an unaccepted result still sits on the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(pop && (head.op == OP_TICK)))
    else $error("tick retired over a pending result");

  // Neutral results carry the same width on all four outputs.
  a_neutral_equal: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == SRC_NEUTRAL)) |->
      ((m_tdata[15:0] == m_tdata[31:16]) && (m_tdata[15:0] == m_tdata[47:32]) &&
       (m_tdata[15:0] == m_tdata[63:48])))
    else $error("neutral result with unequal widths");

  // No result is pending in the first cycle after reset is released.
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== design/rcpfm_queue.sv =====
// Short FIFO of classified events between the front and the back end.
`default_nettype none

module rcpfm_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  wire rcpfm_pkg::q_entry_t push_entry,
  input  wire                      pop,
  output rcpfm_pkg::q_entry_t      head,
  output rcpfm_pkg::q_stat_t       stat
);
  import rcpfm_pkg::*;

  q_entry_t        slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  assign head       = slots[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

// ===== design/rcpfm_front.sv =====
// Front end: accepts input transactions, drops events with no effect, queues the rest.
`default_nettype none

module rcpfm_front (
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [rcpfm_pkg::W_S_TDATA-1:0]     s_tdata,
  input  wire  [1:0]                          s_tuser,
  input  wire  rcpfm_pkg::cfg_t               cfg,
  input  wire  rcpfm_pkg::q_stat_t            q_stat,
  output logic                                push,
  output rcpfm_pkg::q_entry_t                 push_entry
);
  import rcpfm_pkg::*;

  logic [W_CH-1:0]    channel;
  logic [W_WIDTH-1:0] capture_count;
  logic [3:0]         cmd_channel;
  logic [W_CMD-1:0]   cmd_width;
  logic               keep;

  assign channel       = s_tdata[1:0];
  assign capture_count = s_tdata[17:2];
  assign cmd_channel   = s_tdata[21:18];
  assign cmd_width     = s_tdata[33:22];

  assign s_tready = !q_stat.full;

  always_comb begin
    keep             = 1'b0;
    push_entry.op    = OP_TICK;
    push_entry.ch    = channel;
    push_entry.value = capture_count;
    unique case (s_tuser)
      FUNC_CAPTURE: begin
        keep          = 1'b1;
        push_entry.op = OP_CAPTURE;
      end
      FUNC_COMMAND: begin
        // Out-of-range channel numbers and widths outside the bounds are dropped here.
        keep = (cmd_channel >= CMD_CH_FIRST) && (cmd_channel <= CMD_CH_LAST) &&
               (cmd_width >= cfg.cmd_min) && (cmd_width <= cfg.cmd_max);
        push_entry.op    = OP_COMMAND;
        push_entry.ch    = cmd_channel[1:0] - 2'd1;
        push_entry.value = {{(W_WIDTH-W_CMD){1'b0}}, cmd_width};
      end
      FUNC_TICK: begin
        keep          = 1'b1;
        push_entry.op = OP_TICK;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

// ===== design/rcpfm_back.sv =====
// Back end: applies queued events to the channel state and produces tick results.
`default_nettype none

module rcpfm_back (
  input  wire                             clk,
  input  wire                             rst,
  input  wire rcpfm_pkg::cfg_t            cfg,
  input  wire rcpfm_pkg::q_entry_t        head,
  input  wire rcpfm_pkg::q_stat_t         q_stat,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [rcpfm_pkg::W_M_TDATA-1:0] m_tdata,
  output logic [1:0]                      m_tuser
);
  import rcpfm_pkg::*;

  logic [W_WIDTH-1:0] rx_width   [N_CH];
  logic [W_WIDTH-1:0] rx_start   [N_CH];
  logic [W_AGE-1:0]   rx_age     [N_CH];
  logic [N_CH-1:0]    await_fall;
  logic [W_CMD-1:0]   host_width [N_CH];
  logic [W_AGE-1:0]   host_age;
  logic [W_HOLD-1:0]  hold_left;

  logic               out_free;
  logic               do_capture;
  logic               do_command;
  logic               do_tick;
  logic               rx_fresh;
  logic               hold_set;
  logic [W_HOLD-1:0]  hold_eff;
  logic [W_M_TDATA-1:0] tick_data;
  src_t               tick_src;

  assign out_free   = !m_tvalid || m_tready;
  assign pop        = !q_stat.empty && ((head.op != OP_TICK) || out_free);
  assign do_capture = pop && (head.op == OP_CAPTURE);
  assign do_command = pop && (head.op == OP_COMMAND);
  assign do_tick    = pop && (head.op == OP_TICK);

  // Receiver data is fresh only while every channel's age is below the stale limit.
  always_comb begin
    rx_fresh = 1'b1;
    for (int i = 0; i < N_CH; i++) begin
      if (rx_age[i] >= cfg.stale_limit) rx_fresh = 1'b0;
    end
  end

  assign hold_set = rx_fresh &&
                    ((rx_width[0] < cfg.center_low) || (rx_width[0] > cfg.center_high));
  assign hold_eff = hold_set ? cfg.override_hold : hold_left;

  always_comb begin
    if ((hold_eff == '0) && (host_age < cfg.stale_limit)) begin
      tick_src  = SRC_HOST;
      tick_data = {{(W_WIDTH-W_CMD){1'b0}}, host_width[3],
                   {(W_WIDTH-W_CMD){1'b0}}, host_width[2],
                   {(W_WIDTH-W_CMD){1'b0}}, host_width[1],
                   {(W_WIDTH-W_CMD){1'b0}}, host_width[0]};
    end else if (rx_fresh) begin
      tick_src  = SRC_RECEIVER;
      tick_data = {rx_width[3], rx_width[2], rx_width[1], rx_width[0]};
    end else begin
      tick_src  = SRC_NEUTRAL;
      tick_data = {N_CH{cfg.neutral_width}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      await_fall <= '0;
      host_age   <= AGE_RESET;
      hold_left  <= '0;
      for (int i = 0; i < N_CH; i++) begin
        rx_width[i]   <= '0;
        rx_start[i]   <= '0;
        rx_age[i]     <= AGE_RESET;
        host_width[i] <= HOST_WIDTH_RESET;
      end
    end else begin
      if (do_capture) begin
        if (await_fall[head.ch]) begin
          rx_width[head.ch]   <= head.value - rx_start[head.ch];
          rx_age[head.ch]     <= '0;
          await_fall[head.ch] <= 1'b0;
        end else begin
          rx_start[head.ch]   <= head.value;
          await_fall[head.ch] <= 1'b1;
        end
      end
      if (do_command) begin
        host_width[head.ch] <= head.value[W_CMD-1:0];
        host_age            <= '0;
      end
      if (do_tick) begin
        for (int i = 0; i < N_CH; i++) begin
          if (rx_age[i] < AGE_CAP) rx_age[i] <= rx_age[i] + 1'b1;
        end
        if (host_age < AGE_CAP) host_age <= host_age + 1'b1;
        hold_left <= (hold_eff != '0) ? hold_eff - 1'b1 : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      m_tdata <= tick_data;
      m_tuser <= tick_src;
    end
  end

endmodule

`default_nettype wire
